// ===== design/svm_pkg.sv =====
package svm_pkg;

    localparam int DATA_W         = 8;
    localparam int OPCODE_W       = 3;
    localparam int KIND_W         = 2;
    localparam int ERR_W          = 2;
    localparam int REG_IDX_W      = 3;
    localparam int REG_COUNT      = 8;
    localparam int LABEL_W        = 3;
    localparam int PC_INDEX_W     = 5;
    localparam int CFG_ADDR_W     = 8;
    localparam int MEM_DEPTH_DEF  = 256;
    localparam int FUNC_SLOTS_DEF = 8;

    localparam logic [DATA_W-1:0] FRAME_BASE_INIT = 8'd2;
    localparam logic [DATA_W-1:0] LINK_SIZE       = 8'd2;

    localparam logic [REG_IDX_W-1:0] REG_CLR = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_FP  = 3'd5;
    localparam logic [REG_IDX_W-1:0] REG_SP  = 3'd6;
    localparam logic [REG_IDX_W-1:0] REG_PC  = 3'd7;

    localparam logic MODE_START = 1'b0;
    localparam logic MODE_EXEC  = 1'b1;

    typedef enum logic [OPCODE_W-1:0] {
        OP_MOV = 3'd0,
        OP_CAL = 3'd1,
        OP_RET = 3'd2,
        OP_REF = 3'd3,
        OP_ADD = 3'd4,
        OP_PRT = 3'd5,
        OP_NOT = 3'd6,
        OP_EQU = 3'd7
    } opcode_t;

    typedef enum logic [KIND_W-1:0] {
        KIND_VAL  = 2'd0,
        KIND_REG  = 2'd1,
        KIND_SLOT = 2'd2,
        KIND_PTR  = 2'd3
    } kind_t;

    typedef enum logic [ERR_W-1:0] {
        ERR_NONE     = 2'd0,
        ERR_KIND     = 2'd1,
        ERR_OVERFLOW = 2'd2
    } err_t;

    typedef struct packed {
        logic              mode;
        opcode_t           opcode;
        kind_t             dest_kind;
        logic [DATA_W-1:0] dest_value;
        kind_t             src_kind;
        logic [DATA_W-1:0] src_value;
    } instr_t;

    typedef struct packed {
        logic [DATA_W-1:0] rd_addr;
        logic              wr_en;
        logic [DATA_W-1:0] wr_addr;
        logic [DATA_W-1:0] wr_data;
    } dm_req_t;

    typedef struct packed {
        logic [REG_IDX_W-1:0] rd_addr0;
        logic [REG_IDX_W-1:0] rd_addr1;
        logic                 wr_en;
        logic [REG_IDX_W-1:0] wr_addr;
        logic [DATA_W-1:0]    wr_data;
    } rf_req_t;

endpackage

// ===== design/svm_if.sv =====
interface svm_instr_if;
    import svm_pkg::*;
    logic                valid;
    logic                ready;
    logic                mode;
    logic [OPCODE_W-1:0] opcode;
    logic [KIND_W-1:0]   dest_kind;
    logic [DATA_W-1:0]   dest_value;
    logic [KIND_W-1:0]   src_kind;
    logic [DATA_W-1:0]   src_value;

    modport source (
        output valid, mode, opcode, dest_kind, dest_value, src_kind, src_value,
        input  ready
    );
    modport sink (
        input  valid, mode, opcode, dest_kind, dest_value, src_kind, src_value,
        output ready
    );
endinterface

interface svm_result_if;
    import svm_pkg::*;
    logic              valid;
    logic              ready;
    logic [DATA_W-1:0] next_pc;
    logic              print_valid;
    logic [DATA_W-1:0] print_value;
    logic              halted;
    logic [ERR_W-1:0]  error_code;

    modport source (
        output valid, next_pc, print_valid, print_value, halted, error_code,
        input  ready
    );
    modport sink (
        input  valid, next_pc, print_valid, print_value, halted, error_code,
        output ready
    );
endinterface

interface svm_cfg_if;
    import svm_pkg::*;
    logic                  valid;
    logic                  ready;
    logic [CFG_ADDR_W-1:0] addr;
    logic [DATA_W-1:0]     data;

    modport source (
        output valid, addr, data,
        input  ready
    );
    modport sink (
        input  valid, addr, data,
        output ready
    );
endinterface

// ===== design/stack_vm_instruction_executor_top.sv =====
// Channel  Dir  Handshake      Payload
// instr    in   valid/ready    mode, opcode, dest_kind, dest_value, src_kind, src_value
// result   out  valid/ready    next_pc, print_valid, print_value, halted, error_code
// cfg      in   valid/ready    addr (frame size register 0..7), data
//
// An instruction goes through S_RD_A, S_RD_B, S_RD_C (three data memory reads) and S_EXEC;
// start and a call without overflow add S_WR2, as the second link word needs another pass
// through the one write port. The single read port of the data memory sets this order: a
// pointer operand needs two dependent reads before the destination pointer can be read.
// Reset clears registers, halted flag and frame sizes; data memory is not cleared.
// One instruction is buffered at the input while another executes; a finished result
// waits in the output register, and execute holds while that register is still full.
module stack_vm_instruction_executor_top #(
    parameter int MEMORY_DEPTH   = svm_pkg::MEM_DEPTH_DEF,
    parameter int FUNCTION_SLOTS = svm_pkg::FUNC_SLOTS_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    svm_instr_if.sink     instr,
    svm_result_if.source  result,
    svm_cfg_if.sink       cfg
);
    import svm_pkg::*;

    localparam int FS_IDX_W = (FUNCTION_SLOTS > 1) ? $clog2(FUNCTION_SLOTS) : 1;
    localparam logic [CFG_ADDR_W-1:0] FS_CFG_LIMIT = CFG_ADDR_W'(FUNCTION_SLOTS);
    localparam logic [LABEL_W:0]      FS_LABEL_LIMIT = (LABEL_W + 1)'(FUNCTION_SLOTS);

    typedef enum logic [2:0] {
        S_IDLE,
        S_RD_A,
        S_RD_B,
        S_RD_C,
        S_EXEC,
        S_WR2
    } state_t;

    state_t            state_reg, state_next;
    instr_t            hold_reg, hold_next;
    logic              hold_valid_reg, hold_valid_next;
    instr_t            work_reg, work_next;
    logic [DATA_W-1:0] v1_reg, v1_next;
    logic [DATA_W-1:0] v2_reg, v2_next;
    logic [DATA_W-1:0] fp_reg, fp_next;
    logic [DATA_W-1:0] sp_reg, sp_next;
    logic [DATA_W-1:0] pc_reg, pc_next;
    logic              halted_reg, halted_next;
    logic [DATA_W-1:0] wr2_addr_reg, wr2_addr_next;
    logic [DATA_W-1:0] wr2_data_reg, wr2_data_next;
    logic              out_valid_reg, out_valid_next;
    logic [DATA_W-1:0] out_pc_reg, out_pc_next;
    logic              out_pv_reg, out_pv_next;
    logic [DATA_W-1:0] out_pval_reg, out_pval_next;
    logic              out_halt_reg, out_halt_next;
    err_t              out_err_reg, out_err_next;
    logic [DATA_W-1:0] frame_size_reg [FUNCTION_SLOTS];

    dm_req_t           dm_req;
    rf_req_t           rf_req;
    logic [DATA_W-1:0] dm_q;
    logic [DATA_W-1:0] rf_q0;
    logic [DATA_W-1:0] rf_q1;

    logic              accept;
    logic              take;
    logic              go;
    logic              exec_fire;

    svm_dmem #(
        .DEPTH (MEMORY_DEPTH)
    ) u_dmem (
        .clk     (clk),
        .req     (dm_req),
        .rd_data (dm_q)
    );

    svm_rf u_rf (
        .clk      (clk),
        .rst_n    (rst_n),
        .req      (rf_req),
        .rd_data0 (rf_q0),
        .rd_data1 (rf_q1)
    );

    assign instr.ready = !hold_valid_reg;
    assign cfg.ready   = 1'b1;
    assign accept      = instr.valid && !hold_valid_reg;
    assign go          = !out_valid_reg || result.ready;
    assign exec_fire   = (state_reg == S_EXEC) && go;

    assign result.valid       = out_valid_reg;
    assign result.next_pc     = out_pc_reg;
    assign result.print_valid = out_pv_reg;
    assign result.print_value = out_pval_reg;
    assign result.halted      = out_halt_reg;
    assign result.error_code  = out_err_reg;

    always_comb
    begin
        logic [DATA_W-1:0]    s_val;
        kind_t                s_kind;
        logic [DATA_W-1:0]    reg_a;
        logic [DATA_W-1:0]    reg_b;
        logic [DATA_W-1:0]    src_val;
        logic [DATA_W-1:0]    wval;
        logic [DATA_W-1:0]    pc_base;
        logic [DATA_W-1:0]    base;
        logic [DATA_W:0]      sum9;
        logic [LABEL_W-1:0]   fs_label;
        logic [DATA_W-1:0]    fs_val;
        logic [REG_IDX_W-1:0] d_idx;
        logic                 do_write;
        logic                 need_wr2;

        s_val  = (work_reg.opcode == OP_PRT) ? work_reg.dest_value : work_reg.src_value;
        s_kind = (work_reg.opcode == OP_PRT) ? work_reg.dest_kind  : work_reg.src_kind;
        d_idx  = work_reg.dest_value[REG_IDX_W-1:0];

        case (d_idx)
            REG_FP:  reg_a = fp_reg;
            REG_SP:  reg_a = sp_reg;
            REG_PC:  reg_a = pc_reg;
            default: reg_a = rf_q0;
        endcase
        case (work_reg.src_value[REG_IDX_W-1:0])
            REG_FP:  reg_b = fp_reg;
            REG_SP:  reg_b = sp_reg;
            REG_PC:  reg_b = pc_reg;
            default: reg_b = rf_q1;
        endcase

        case (s_kind)
            KIND_VAL:  src_val = s_val;
            KIND_REG:  src_val = (work_reg.opcode == OP_PRT) ? reg_a : reg_b;
            KIND_SLOT: src_val = v1_reg;
            default:   src_val = v2_reg;
        endcase

        if (work_reg.mode == MODE_START)
        begin
            fs_label = '0;
        end
        else if (work_reg.opcode == OP_RET)
        begin
            fs_label = v1_reg[DATA_W-1 -: LABEL_W];
        end
        else
        begin
            fs_label = work_reg.dest_value[LABEL_W-1:0];
        end
        // labels without a function slot have an empty frame
        fs_val = ({1'b0, fs_label} < FS_LABEL_LIMIT)
               ? frame_size_reg[fs_label[FS_IDX_W-1:0]] : '0;

        base = sp_reg + LINK_SIZE;
        sum9 = {1'b0, base} + {1'b0, fs_val};

        state_next      = state_reg;
        hold_next       = hold_reg;
        hold_valid_next = hold_valid_reg;
        work_next       = work_reg;
        v1_next         = v1_reg;
        v2_next         = v2_reg;
        fp_next         = fp_reg;
        sp_next         = sp_reg;
        pc_next         = pc_reg;
        halted_next     = halted_reg;
        wr2_addr_next   = wr2_addr_reg;
        wr2_data_next   = wr2_data_reg;
        out_valid_next  = out_valid_reg && !result.ready;
        out_pc_next     = out_pc_reg;
        out_pv_next     = out_pv_reg;
        out_pval_next   = out_pval_reg;
        out_halt_next   = out_halt_reg;
        out_err_next    = out_err_reg;

        dm_req.rd_addr = fp_reg + work_reg.dest_value;
        dm_req.wr_en   = 1'b0;
        dm_req.wr_addr = '0;
        dm_req.wr_data = '0;

        rf_req.rd_addr0 = d_idx;
        rf_req.rd_addr1 = work_reg.src_value[REG_IDX_W-1:0];
        rf_req.wr_en    = 1'b0;
        rf_req.wr_addr  = d_idx;
        rf_req.wr_data  = '0;

        wval     = '0;
        do_write = 1'b0;
        need_wr2 = 1'b0;
        take     = 1'b0;

        if (accept)
        begin
            hold_next = '{
                mode:       instr.mode,
                opcode:     opcode_t'(instr.opcode),
                dest_kind:  kind_t'(instr.dest_kind),
                dest_value: instr.dest_value,
                src_kind:   kind_t'(instr.src_kind),
                src_value:  instr.src_value
            };
            hold_valid_next = 1'b1;
        end

        case (state_reg)
            S_IDLE:
            begin
                take = hold_valid_reg;
            end
            S_RD_A:
            begin
                // return reads the link words below the frame base
                dm_req.rd_addr = (work_reg.opcode == OP_RET)
                               ? fp_reg - 8'd1 : fp_reg + s_val;
                state_next = S_RD_B;
            end
            S_RD_B:
            begin
                v1_next = dm_q;
                dm_req.rd_addr = (work_reg.opcode == OP_RET) ? fp_reg - 8'd2 : dm_q;
                state_next = S_RD_C;
            end
            S_RD_C:
            begin
                v2_next = dm_q;
                state_next = S_EXEC;
            end
            S_EXEC:
            begin
                // dm_q now holds the destination pointer
                if (go)
                begin
                    out_pv_next   = 1'b0;
                    out_pval_next = '0;
                    out_err_next  = ERR_NONE;
                    if (work_reg.mode == MODE_START)
                    begin
                        pc_next        = '0;
                        fp_next        = FRAME_BASE_INIT;
                        sp_next        = FRAME_BASE_INIT + fs_val;
                        halted_next    = 1'b0;
                        rf_req.wr_en   = 1'b1;
                        rf_req.wr_addr = REG_CLR;
                        rf_req.wr_data = '0;
                        dm_req.wr_en   = 1'b1;
                        dm_req.wr_addr = '0;
                        dm_req.wr_data = '0;
                        wr2_addr_next  = 8'd1;
                        wr2_data_next  = FRAME_BASE_INIT;
                        need_wr2       = 1'b1;
                    end
                    else if (!halted_reg)
                    begin
                        case (work_reg.opcode)
                            OP_MOV:
                            begin
                                if (work_reg.dest_kind == KIND_VAL)
                                begin
                                    out_err_next = ERR_KIND;
                                end
                                else
                                begin
                                    do_write = 1'b1;
                                    wval     = src_val;
                                end
                            end
                            OP_CAL:
                            begin
                                if (sum9[DATA_W])
                                begin
                                    out_err_next = ERR_OVERFLOW;
                                end
                                else
                                begin
                                    dm_req.wr_en   = 1'b1;
                                    dm_req.wr_addr = sp_reg;
                                    dm_req.wr_data = fp_reg;
                                    wr2_addr_next  = sp_reg + 8'd1;
                                    wr2_data_next  = pc_reg + 8'd1;
                                    need_wr2       = 1'b1;
                                    fp_next        = base;
                                    pc_next        = {work_reg.dest_value[LABEL_W-1:0],
                                                      PC_INDEX_W'(0)};
                                    sp_next        = sum9[DATA_W-1:0];
                                end
                            end
                            OP_RET:
                            begin
                                if (pc_reg[DATA_W-1 -: LABEL_W] == '0)
                                begin
                                    halted_next = 1'b1;
                                end
                                else
                                begin
                                    pc_next = v1_reg;
                                    fp_next = v2_reg;
                                    sp_next = v2_reg + fs_val;
                                end
                            end
                            OP_REF:
                            begin
                                if (work_reg.dest_kind == KIND_VAL ||
                                    work_reg.src_kind == KIND_VAL ||
                                    work_reg.src_kind == KIND_REG)
                                begin
                                    out_err_next = ERR_KIND;
                                end
                                else
                                begin
                                    do_write = 1'b1;
                                    wval     = (work_reg.src_kind == KIND_SLOT)
                                             ? fp_reg + work_reg.src_value : v1_reg;
                                end
                            end
                            OP_ADD:
                            begin
                                if (work_reg.dest_kind != KIND_REG ||
                                    work_reg.src_kind != KIND_REG)
                                begin
                                    out_err_next = ERR_KIND;
                                end
                                else
                                begin
                                    do_write = 1'b1;
                                    wval     = reg_a + reg_b;
                                end
                            end
                            OP_PRT:
                            begin
                                out_pv_next   = 1'b1;
                                out_pval_next = src_val;
                                pc_next       = pc_reg + 8'd1;
                            end
                            OP_NOT:
                            begin
                                if (work_reg.dest_kind != KIND_REG)
                                begin
                                    out_err_next = ERR_KIND;
                                end
                                else
                                begin
                                    do_write = 1'b1;
                                    wval     = ~reg_a;
                                end
                            end
                            default:
                            begin
                                if (work_reg.dest_kind != KIND_REG)
                                begin
                                    out_err_next = ERR_KIND;
                                end
                                else
                                begin
                                    do_write = 1'b1;
                                    wval     = (reg_a == '0) ? 8'd1 : 8'd0;
                                end
                            end
                        endcase

                        if (do_write)
                        begin
                            pc_base = pc_reg;
                            case (work_reg.dest_kind)
                                KIND_REG:
                                begin
                                    case (d_idx)
                                        REG_FP:  fp_next = wval;
                                        REG_SP:  sp_next = wval;
                                        REG_PC:  pc_base = wval;
                                        default:
                                        begin
                                            rf_req.wr_en   = 1'b1;
                                            rf_req.wr_data = wval;
                                        end
                                    endcase
                                end
                                KIND_SLOT:
                                begin
                                    dm_req.wr_en   = 1'b1;
                                    dm_req.wr_addr = fp_reg + work_reg.dest_value;
                                    dm_req.wr_data = wval;
                                end
                                KIND_PTR:
                                begin
                                    dm_req.wr_en   = 1'b1;
                                    dm_req.wr_addr = dm_q;
                                    dm_req.wr_data = wval;
                                end
                                default:
                                begin
                                end
                            endcase
                            pc_next = pc_base + 8'd1;
                        end
                    end

                    out_valid_next = 1'b1;
                    out_pc_next    = pc_next;
                    out_halt_next  = halted_next;

                    if (need_wr2)
                    begin
                        state_next = S_WR2;
                    end
                    else
                    begin
                        take = hold_valid_reg;
                    end
                end
            end
            S_WR2:
            begin
                dm_req.wr_en   = 1'b1;
                dm_req.wr_addr = wr2_addr_reg;
                dm_req.wr_data = wr2_data_reg;
                take = hold_valid_reg;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (state_reg == S_IDLE || state_reg == S_WR2 || exec_fire)
        begin
            if (take)
            begin
                work_next       = hold_reg;
                hold_valid_next = 1'b0;
                state_next      = S_RD_A;
            end
            else if (state_next != S_WR2)
            begin
                state_next = S_IDLE;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            hold_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
            fp_reg         <= '0;
            sp_reg         <= '0;
            pc_reg         <= '0;
            halted_reg     <= 1'b0;
            for (int i = 0; i < FUNCTION_SLOTS; i++)
            begin
                frame_size_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg      <= state_next;
            hold_valid_reg <= hold_valid_next;
            out_valid_reg  <= out_valid_next;
            fp_reg         <= fp_next;
            sp_reg         <= sp_next;
            pc_reg         <= pc_next;
            halted_reg     <= halted_next;
            if (cfg.valid && cfg.addr < FS_CFG_LIMIT)
            begin
                frame_size_reg[cfg.addr[FS_IDX_W-1:0]] <= cfg.data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        hold_reg     <= hold_next;
        work_reg     <= work_next;
        v1_reg       <= v1_next;
        v2_reg       <= v2_next;
        wr2_addr_reg <= wr2_addr_next;
        wr2_data_reg <= wr2_data_next;
        out_pc_reg   <= out_pc_next;
        out_pv_reg   <= out_pv_next;
        out_pval_reg <= out_pval_next;
        out_halt_reg <= out_halt_next;
        out_err_reg  <= out_err_next;
    end

`ifndef NO_ASSERTIONS
    a_err_keeps_state: assert property (@(posedge clk) disable iff (!rst_n)
        (exec_fire && out_err_next != ERR_NONE)
        |=> (pc_reg == $past(pc_reg) && fp_reg == $past(fp_reg) && sp_reg == $past(sp_reg)))
        else $error("faulting instruction changed machine state");

    a_wr2_only_link: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_WR2)
        |-> (work_reg.mode == MODE_START || work_reg.opcode == OP_CAL))
        else $error("second write pass outside start or call");

    a_halt_on_ret: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(halted_reg)
        |-> ($past(work_reg.opcode) == OP_RET && $past(work_reg.mode) == MODE_EXEC))
        else $error("halt raised by something other than a return");
`endif

endmodule

// ===== design/svm_dmem.sv =====
module svm_dmem #(
    parameter int DEPTH = svm_pkg::MEM_DEPTH_DEF
) (
    input  logic                      clk,
    input  svm_pkg::dm_req_t          req,
    output logic [svm_pkg::DATA_W-1:0] rd_data
);
    import svm_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam logic [DATA_W:0] DEPTH_W = (DATA_W + 1)'(DEPTH);

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rd_data_reg;

    // byte address folded into the memory range; at most three subtractions
    function automatic logic [AW-1:0] fold(input logic [DATA_W-1:0] a);
        logic [DATA_W:0] r;
        r = {1'b0, a};
        for (int i = 0; i < 3; i++)
        begin
            if (r >= DEPTH_W)
            begin
                r = r - DEPTH_W;
            end
        end
        return r[AW-1:0];
    endfunction

    always_ff @(posedge clk)
    begin
        if (req.wr_en)
        begin
            mem[fold(req.wr_addr)] <= req.wr_data;
        end
        rd_data_reg <= mem[fold(req.rd_addr)];
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== design/svm_rf.sv =====
module svm_rf (
    input  logic                       clk,
    input  logic                       rst_n,
    input  svm_pkg::rf_req_t           req,
    output logic [svm_pkg::DATA_W-1:0] rd_data0,
    output logic [svm_pkg::DATA_W-1:0] rd_data1
);
    import svm_pkg::*;

    logic [DATA_W-1:0]    mem [REG_COUNT];
    logic [REG_COUNT-1:0] valid_reg;
    logic [DATA_W-1:0]    rd0_reg;
    logic [DATA_W-1:0]    rd1_reg;
    logic                 rv0_reg;
    logic                 rv1_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            rv0_reg   <= 1'b0;
            rv1_reg   <= 1'b0;
        end
        else
        begin
            if (req.wr_en)
            begin
                valid_reg[req.wr_addr] <= 1'b1;
            end
            rv0_reg <= valid_reg[req.rd_addr0];
            rv1_reg <= valid_reg[req.rd_addr1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.wr_en)
        begin
            mem[req.wr_addr] <= req.wr_data;
        end
        rd0_reg <= mem[req.rd_addr0];
        rd1_reg <= mem[req.rd_addr1];
    end

    // never-written entries read as zero
    assign rd_data0 = rv0_reg ? rd0_reg : '0;
    assign rd_data1 = rv1_reg ? rd1_reg : '0;

endmodule
